### design/blcg_pkg.sv
// ============================================================================
// Line rasterizer package
// Shared widths, payload structs and the queue entry type for the rasterizer.
// ============================================================================
package blcg_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COLOR_BITS     = 24;
    localparam int CHAN_BITS      = 8;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // Input word at the default coordinate width.
    typedef struct packed {
        logic                             kind;
        logic signed [COORD_BITS_DEF-1:0] start_x;
        logic signed [COORD_BITS_DEF-1:0] start_y;
        logic signed [COORD_BITS_DEF-1:0] end_x;
        logic signed [COORD_BITS_DEF-1:0] end_y;
        logic [COLOR_BITS-1:0]            start_color;
        logic [COLOR_BITS-1:0]            end_color;
    } t_in_word;

    // Output word at the default coordinate width.
    typedef struct packed {
        logic signed [COORD_BITS_DEF-1:0] pixel_x;
        logic signed [COORD_BITS_DEF-1:0] pixel_y;
        logic [COLOR_BITS-1:0]            pixel_color;
        logic                             last;
    } t_out_word;

endpackage

### design/blcg_front.sv
// ============================================================================
// Line rasterizer front end
// Accepts input words and queues them in a two-entry queue for the back end,
// which decides whether a step word belongs to an active line.
// ============================================================================
module blcg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  blcg_pkg::t_in_word  i_word,
    output logic                o_q_valid,
    input  logic                i_q_pop,
    output blcg_pkg::t_in_word  o_q_word
);

    blcg_pkg::t_in_word r_q [2];
    logic               r_rd;
    logic               r_wr;
    logic [1:0]         r_cnt;
    logic               push;
    logic               pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign pop       = i_q_pop && (r_cnt != 2'd0);
    // Every accepted word is queued; stray steps are discarded by the back end,
    // which knows whether the line before them has ended.
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_q[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_word;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= 1'b0;
            r_wr   <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### design/blcg_back.sv
// ============================================================================
// Line rasterizer back end
// Carries out loads and Bresenham steps and blends each pixel color with a
// shared serial divider, one quotient bit per cycle over three channels.
// ============================================================================
module blcg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  blcg_pkg::t_in_word  i_q_word,
    output logic                o_valid,
    input  logic                i_stall,
    output blcg_pkg::t_out_word o_word
);

    localparam int CB = blcg_pkg::COORD_BITS_DEF;
    localparam int DB = CB + 1;
    localparam int EB = CB + 3;
    localparam int QB = 9;
    localparam int PB = DB + 8;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} t_state;

    t_state                r_state;
    logic                  r_active;
    logic signed [CB-1:0]  r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic [CB-1:0]         r_dx, r_dy;
    logic                  r_sxn, r_syn;
    logic signed [EB-1:0]  r_err;
    logic [DB-1:0]         r_dist, r_total;
    logic [23:0]           r_ca, r_cb;
    logic [1:0]            r_ch;
    logic [3:0]            r_bit;
    logic [PB-1:0]         r_rem;
    logic [QB-1:0]         r_quo;
    logic [23:0]           r_color;
    logic                  r_out_v;
    blcg_pkg::t_out_word   r_out;

    // Load decode.
    logic signed [CB-1:0]  sx, sy, ex, ey;
    logic [CB-1:0]         ldx, ldy;
    logic signed [EB-1:0]  e2, ndy, sdx;
    logic                  mv_x, mv_y;
    logic [7:0]            ca_ch, cb_ch, mag;
    logic                  neg;
    logic [PB-1:0]         prod;
    logic [PB:0]           trial;
    logic [7:0]            blended;

    assign sx  = i_q_word.start_x[CB-1:0];
    assign sy  = i_q_word.start_y[CB-1:0];
    assign ex  = i_q_word.end_x[CB-1:0];
    assign ey  = i_q_word.end_y[CB-1:0];
    assign ldx = (ex >= sx) ? CB'(ex - sx) : CB'(sx - ex);
    assign ldy = (ey >= sy) ? CB'(ey - sy) : CB'(sy - ey);

    assign e2   = r_err <<< 1;
    assign ndy  = -$signed({{(EB-CB){1'b0}}, r_dy});
    assign sdx  = $signed({{(EB-CB){1'b0}}, r_dx});
    assign mv_x = e2 > ndy;
    assign mv_y = e2 < sdx;

    // Channel blend: remainder holds mag*dist; one restoring step per cycle.
    assign ca_ch   = r_ca[8*r_ch +: 8];
    assign cb_ch   = r_cb[8*r_ch +: 8];
    assign neg     = cb_ch < ca_ch;
    assign mag     = neg ? ca_ch - cb_ch : cb_ch - ca_ch;
    assign prod    = PB'(mag) * PB'(r_dist);
    assign trial   = {1'b0, r_rem} - ({1'b0, r_total, 8'd0} >> (8 - r_bit));
    assign blended = neg ? ca_ch - r_quo[7:0] : ca_ch + r_quo[7:0];

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_valid     = r_out_v;
    assign o_word      = r_out;

    // Sequencer: take an item, run the blend, then hand the word to the output; a step with no active line is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && !i_stall && r_state != S_OUT) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_word.kind == blcg_pkg::KIND_LOAD) begin
                            r_dx    <= ldx;
                            r_dy    <= ldy;
                            r_sxn   <= !(sx < ex);
                            r_syn   <= !(sy < ey);
                            r_err   <= EB'($signed({1'b0, ldx})) - EB'($signed({1'b0, ldy}));
                            r_total <= DB'(ldx) + DB'(ldy);
                            r_dist  <= '0;
                            r_cur_x <= sx;
                            r_cur_y <= sy;
                            r_goal_x <= ex;
                            r_goal_y <= ey;
                            r_ca    <= i_q_word.start_color;
                            r_cb    <= i_q_word.end_color;
                            r_ch    <= 2'd0;
                            r_state <= S_DIV;
                            r_bit   <= 4'd9;
                        end else if (r_active) begin
                            if (mv_x) begin
                                r_cur_x <= r_cur_x + (r_sxn ? CB'(-1) : CB'(1));
                            end
                            if (mv_y) begin
                                r_cur_y <= r_cur_y + (r_syn ? CB'(-1) : CB'(1));
                            end
                            r_err  <= r_err - (mv_x ? EB'(r_dy) : '0) + (mv_y ? sdx : '0);
                            r_dist <= r_dist + DB'(mv_x) + DB'(mv_y);
                            r_ch    <= 2'd0;
                            r_state <= S_DIV;
                            r_bit   <= 4'd9;
                        end
                    end
                end
                S_DIV: begin
                    // Bit nine primes the remainder, bits eight to zero divide,
                    // and bit ten stores the blended channel.
                    if (r_bit == 4'd10) begin
                        r_color[8*r_ch +: 8] <= blended;
                        r_bit <= 4'd9;
                        if (r_ch == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ch <= r_ch + 2'd1;
                        end
                    end else if (r_bit == 4'd9) begin
                        r_rem <= prod;
                        r_quo <= '0;
                        r_bit <= 4'd8;
                    end else begin
                        if (!trial[PB]) begin
                            r_rem <= trial[PB-1:0];
                            r_quo <= r_quo | (QB'(1) << r_bit);
                        end
                        if (r_bit == 4'd0) begin
                            r_bit <= 4'd10;
                        end else begin
                            r_bit <= r_bit - 4'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_v || !i_stall) begin
                        r_out.pixel_x <= 16'($signed(r_cur_x));
                        r_out.pixel_y <= 16'($signed(r_cur_y));
                        r_out.pixel_color <= (r_total == '0 || r_dist == '0) ? r_ca :
                                             (r_dist >= r_total) ? r_cb : r_color;
                        r_out.last <= (r_cur_x == r_goal_x) && (r_cur_y == r_goal_y);
                        r_active   <= !((r_cur_x == r_goal_x) && (r_cur_y == r_goal_y));
                        r_out_v    <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### design/bresenham_line_color_gradient_top.sv
// ============================================================================
// Line rasterizer top level
// Bresenham line walker with per-pixel RGB interpolation.
// ============================================================================
// Usage: the input channel takes one word per load or step (kind 0 = load a
// line and emit its first pixel, kind 1 = advance one step). Each load or
// active step yields one output word; steps with no active line are dropped.
// A front end queues words in a two-entry queue; the back end computes.
// An accepted word is taken from the queue, then the shared serial divider
// blends each color channel in turn, one quotient bit per cycle, and the
// output word is registered.
// The back end takes no new word until the output word of the last one is
// registered; a dropped step is popped without computing a pixel.
// Reset clears the line state; no line is active afterwards.
// When the receiver stalls, the output word holds, the back end waits after
// its next pixel, and the input stalls once the queue is full.
// A step is judged in the back end against the line state left by the word
// before it, so a step following the final pixel of a line is dropped.
// ============================================================================
module bresenham_line_color_gradient_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  blcg_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output blcg_pkg::t_out_word o_word
);

    logic               q_valid;
    logic               q_pop;
    blcg_pkg::t_in_word q_word;

    // Front end: accept and queue.
    blcg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_word    (q_word)
    );

    // Back end: step and blend.
    blcg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_word    (q_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word)
    );

endmodule
